// ===== src/cfl_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the CFL step block.
`timescale 1ns / 1ps
`default_nettype none
package cfl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int TS_W          = 36;
    localparam int ORDER_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int STEP_CAP_INT  = 1000000;
    localparam int CAP_BITS      = $clog2(STEP_CAP_INT + 1);
    localparam int GH_W          = 2 * IN_W;
    localparam int ROOT_W        = IN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;

    localparam logic [IN_W-1:0]    THRESH_RST = 32'd66;
    localparam logic [IN_W-1:0]    GRAV_RST   = 32'd642908;
    localparam logic [ORDER_W-1:0] ORDER_RST  = 4'd1;

    typedef struct packed {
        logic load;
        logic start1;
        logic load_den;
        logic start2;
        logic update;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic wet;
        logic div_done;
        logic sqrt_done;
        logic den_zero;
        logic last;
        logic out_full;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== src/cfl_if.sv =====
// Channel interfaces: node input, step result and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface cfl_node_if;
    logic               valid;
    logic               ready;
    logic        [31:0] depth;
    logic signed [31:0] discharge;
    logic        [31:0] cell_width;
    logic               dry_cell;
    logic               last_node;
    modport source(output valid, depth, discharge, cell_width, dry_cell, last_node,
                   input ready);
    modport sink(input valid, depth, discharge, cell_width, dry_cell, last_node,
                 output ready);
endinterface

interface cfl_step_if;
    logic        valid;
    logic        ready;
    logic [35:0] time_step;
    modport source(output valid, time_step, input ready);
    modport sink(input valid, time_step, output ready);
endinterface

interface cfl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/cfl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cfl_div #(
    parameter int NW = 48,
    parameter int DW = 54
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic      [NW-1:0] o_quotient,
    output logic               o_done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done)) else $error("divider busy and done together");
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1) && !i_start) |=> r_done)
        else $error("divider did not finish");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0) else $error("divider count left over");

endmodule
`default_nettype wire

// ===== src/cfl_sqrt.sv =====
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cfl_sqrt
    import cfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [GH_W-1:0]   i_value,
    output logic      [ROOT_W-1:0] o_root,
    output logic                   o_done
);
    localparam int CW = $clog2(ROOT_W + 1);
    localparam int RW = ROOT_W + 2;

    logic [GH_W-1:0]   r_val;
    logic [RW-1:0]     r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RW+1:0]     trial_rem;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              ge;

    assign trial_rem = {r_rem, r_val[GH_W-1 -: 2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign diff      = trial_rem - trial;
    assign ge        = trial_rem >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[RW-1:0] : trial_rem[RW-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_val  <= {r_val[GH_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== src/cfl_datapath.sv =====
// Datapath: config registers, operand capture, divider, root unit, minimum and result register.
`timescale 1ns / 1ps
`default_nettype none
module cfl_datapath
    import cfl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [IN_W-1:0]      i_depth,
    input  wire logic [IN_W-1:0]      i_discharge,
    input  wire logic [IN_W-1:0]      i_cell_width,
    input  wire logic                 i_dry_cell,
    input  wire logic                 i_last_node,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [IN_W-1:0]      i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic      [TS_W-1:0]      o_time_step
);
    localparam int NW = IN_W + FRAC_BITS;
    localparam int DW = NW + ORDER_W + 2;
    localparam int MW = CAP_BITS + FRAC_BITS;
    localparam int OW = (MW > TS_W) ? MW : TS_W;
    localparam logic [MW-1:0] CAP = MW'(STEP_CAP_INT) << FRAC_BITS;

    logic [IN_W-1:0]    r_thresh;
    logic [IN_W-1:0]    r_grav;
    logic [ORDER_W-1:0] r_order;
    logic [IN_W-1:0]    r_h;
    logic [IN_W-1:0]    r_qmag;
    logic [IN_W-1:0]    r_w;
    logic               r_wet;
    logic               r_last;
    logic [GH_W-1:0]    r_gh;
    logic [DW-1:0]      r_den;
    logic [MW-1:0]      r_min;
    logic               r_out_valid;
    logic [TS_W-1:0]    r_out_ts;

    logic [NW-1:0]      div_dividend;
    logic [DW-1:0]      div_divisor;
    logic [NW-1:0]      quo;
    logic               div_done;
    logic [ROOT_W-1:0]  root;
    logic               sqrt_done;
    logic [NW:0]        speed_sum;
    logic [OW-1:0]      min_ext;
    logic [TS_W-1:0]    min_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_grav   <= GRAV_RST;
            r_order  <= ORDER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESH: r_thresh <= i_cfg_data;
                CFG_GRAV:   r_grav   <= i_cfg_data;
                CFG_ORDER:  r_order  <= i_cfg_data[ORDER_W-1:0];
                default:    ;
            endcase
        end
    end

    // Node capture; the gravity product is formed at capture time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_h    <= i_depth;
            r_qmag <= i_discharge[IN_W-1] ? (~i_discharge + 1'b1) : i_discharge;
            r_w    <= i_cell_width;
            r_wet  <= !i_dry_cell && (i_depth >= r_thresh) && (i_depth != '0);
            r_last <= i_last_node;
            r_gh   <= GH_W'(r_grav) * GH_W'(i_depth);
        end
        if (i_cmd.load_den) begin
            r_den <= DW'(speed_sum) * DW'({r_order, 1'b1});
        end
    end

    assign speed_sum    = {1'b0, quo} + (NW + 1)'(root);
    assign div_dividend = i_cmd.start2 ? {r_w, FRAC_BITS'(0)} : {r_qmag, FRAC_BITS'(0)};
    assign div_divisor  = i_cmd.start2 ? r_den : DW'(r_h);

    cfl_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start1 || i_cmd.start2),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    cfl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start1),
        .i_value (r_gh),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    assign min_ext = OW'(r_min);
    assign min_sat = (min_ext > OW'({TS_W{1'b1}})) ? {TS_W{1'b1}} : min_ext[TS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= CAP;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_min       <= CAP;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.update && (quo < NW'(r_min))) begin
                    r_min <= quo[MW-1:0];
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ts <= min_sat;
        end
    end

    assign o_sts.wet       = r_wet;
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.den_zero  = (r_den == '0);
    assign o_sts.last      = r_last;
    assign o_sts.out_full  = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_time_step     = r_out_ts;

    a_min_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= CAP) else $error("running minimum above cap");
    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_min == CAP) && r_out_valid) else $error("emit did not restart");
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid) else $error("result overwritten");

endmodule
`default_nettype wire

// ===== src/cfl_ctrl.sv =====
// Controller state machine sequencing one node through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module cfl_ctrl
    import cfl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_RUN1, S_MUL, S_KICK2, S_RUN2, S_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= i_sts.wet ? S_RUN1 : S_FINISH;
                end
                S_RUN1: begin
                    if (i_sts.div_done && i_sts.sqrt_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_KICK2;
                end
                S_KICK2: begin
                    r_state <= i_sts.den_zero ? S_FINISH : S_RUN2;
                end
                S_RUN2: begin
                    if (i_sts.div_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!i_sts.last || !i_sts.out_full) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.start1   = (r_state == S_PREP) && i_sts.wet;
        o_cmd.load_den = (r_state == S_MUL);
        o_cmd.start2   = (r_state == S_KICK2) && !i_sts.den_zero;
        o_cmd.update   = (r_state == S_RUN2) && i_sts.div_done;
        o_cmd.emit     = (r_state == S_FINISH) && i_sts.last && !i_sts.out_full;
    end

    assign o_in_ready = r_in_ready;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.start1 && o_cmd.start2)) else $error("two divider starts");
    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_in_ready) |=> !r_in_ready) else $error("ready held after beat");

endmodule
`default_nettype wire

// ===== src/cfl_time_step_min_swe1d.sv =====
// Top level of the CFL time-step minimum for a 1-D shallow-water sweep.
//
//  channel   | dir | payload                                         | beat when
//  ----------+-----+-------------------------------------------------+-----------------
//  i_node    | in  | depth, discharge, cell_width, dry_cell, last_node| valid && ready
//  o_step    | out | time_step (unsigned Q20.16)                     | valid && ready
//  i_cfg     | in  | index (0 threshold, 1 gravity, 2 order), data   | valid (always ready)
//
// For a wet node the shared bit-serial divider runs twice, once for velocity and
// once for the local step, while the root unit overlaps the first division; the
// second is skipped when the denominator is zero. Reset (synchronous, active low)
// restores the register defaults and a running minimum of 1e6. A result waits in
// an output register; new nodes are taken while it waits, and only a further last
// node stalls until the pending beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module cfl_time_step_min_swe1d
    import cfl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cfl_node_if.sink    i_node,
    cfl_step_if.source  o_step,
    cfl_cfg_if.sink     i_cfg
);
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;
    logic [TS_W-1:0] time_step;

    assign i_node.ready = in_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_step.valid = out_valid;
    assign o_step.time_step = time_step;

    // Sequencer: captures a node, runs the divisions and root, then updates the minimum and emits at a last node.
    cfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_node.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cfl_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_depth      (i_node.depth),
        .i_discharge  (i_node.discharge),
        .i_cell_width (i_node.cell_width),
        .i_dry_cell   (i_node.dry_cell),
        .i_last_node  (i_node.last_node),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_step.ready),
        .o_out_valid  (out_valid),
        .o_time_step  (time_step)
    );

endmodule
`default_nettype wire

// ===== dv/cfl_tb_pkg.sv =====
// Testbench constants shared by the stimulus top and the step checker.
`timescale 1ns / 1ps
package cfl_tb_pkg;

    localparam int          TB_FRAC    = 16;
    localparam logic [63:0] MIN_START  = 64'd1000000 << TB_FRAC;
    localparam logic [35:0] STEP_SAT   = 36'hF_FFFF_FFFF;
    localparam int          WET_CYCLES = 2 * (32 + TB_FRAC) + 6;

endpackage

// ===== dv/cfl_step_checker.sv =====
// Checker that predicts the CFL time step from node beats and compares results.
`timescale 1ns / 1ps
module cfl_step_checker
    import cfl_pkg::*;
    import cfl_tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfl_node_if        node,
    cfl_step_if        step,
    cfl_cfg_if         cfg,
    output int         o_errors,
    output int         o_pending
);

    logic [31:0] thresh_q;
    logic [31:0] grav_q;
    logic [3:0]  order_q;
    logic [63:0] min_q;
    logic [35:0] step_queue[$];

    // Bit-by-bit integer square root of a 64-bit value.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] bitv;
        root = 0;
        rem  = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Local step for one wet node, or all ones when the summed speed (flow plus wave) is zero.
    function automatic logic [63:0] local_step(input logic [31:0] h, input logic [31:0] q,
                                               input logic [31:0] w);
        logic [63:0] qmag;
        logic [63:0] speed;
        logic [63:0] wave;
        logic [63:0] denom;
        qmag  = q[31] ? {32'd0, -q} : {32'd0, q};
        speed = (qmag << TB_FRAC) / h;
        wave  = int_sqrt({32'd0, grav_q} * {32'd0, h});
        denom = (speed + wave) * (2 * {60'd0, order_q} + 64'd1);
        if (denom == 0) return '1;
        return ({32'd0, w} << TB_FRAC) / denom;
    endfunction

    assign o_pending = step_queue.size();

    always @(posedge i_clk) begin
        logic [63:0] loc;
        logic [35:0] want;
        if (!i_rst_n) begin
            thresh_q <= THRESH_RST;
            grav_q   <= GRAV_RST;
            order_q  <= ORDER_RST;
            min_q    <= MIN_START;
            o_errors <= 0;
            step_queue.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_THRESH: thresh_q <= cfg.data;
                    CFG_GRAV:   grav_q   <= cfg.data;
                    CFG_ORDER:  order_q  <= cfg.data[3:0];
                    default: ;
                endcase
            end
            if (node.valid && node.ready) begin
                loc = min_q;
                if (!node.dry_cell && node.depth >= thresh_q && node.depth != 0) begin
                    if (local_step(node.depth, node.discharge, node.cell_width) < loc)
                        loc = local_step(node.depth, node.discharge, node.cell_width);
                end
                if (node.last_node) begin
                    step_queue.push_back(loc > {28'd0, STEP_SAT} ? STEP_SAT : loc[35:0]);
                    min_q <= MIN_START;
                end else begin
                    min_q <= loc;
                end
            end
            if (step.valid && step.ready) begin
                if (step_queue.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("Unexpected time step beat: %0d", step.time_step);
                end else begin
                    want = step_queue.pop_front();
                    if (want !== step.time_step) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("Time step mismatch: expected %0d, got %0d",
                                     want, step.time_step);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus top for the CFL time-step minimum block.
`timescale 1ns / 1ps
module tb_top;
    import cfl_pkg::*;
    import cfl_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;

    cfl_node_if node_ch();
    cfl_step_if step_ch();
    cfl_cfg_if  cfg_ch();

    cfl_time_step_min_swe1d dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_node (node_ch),
        .o_step (step_ch),
        .i_cfg  (cfg_ch)
    );

    cfl_step_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .node     (node_ch),
        .step     (step_ch),
        .cfg      (cfg_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // The run ends here if the block hangs; the slowest correct run is far shorter.
    initial begin
        #(64'd20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The result side holds ready low for a random stall, possibly none, before each beat.
    initial begin
        int stall;
        step_ch.ready = 0;
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 5);
            if (stall != 0) begin
                step_ch.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            step_ch.ready <= 1;
            @(posedge i_clk);
            while (!step_ch.valid) @(posedge i_clk);
        end
    end

    // Sends one node beat after a random gap; valid stays high until accepted.
    // Valid drops only when a gap follows, so a zero gap keeps it high.
    task automatic send_node(input logic [31:0] h, input logic [31:0] q,
                             input logic [31:0] w, input logic dry, input logic last);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            node_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        node_ch.valid      <= 1;
        node_ch.depth      <= h;
        node_ch.discharge  <= q;
        node_ch.cell_width <= w;
        node_ch.dry_cell   <= dry;
        node_ch.last_node  <= last;
        @(posedge i_clk);
        while (!node_ch.ready) @(posedge i_clk);
    endtask

    // Register writes happen only when the block is idle: every result is in and a
    // wet node, which produces no beat of its own, has had time to finish.
    task automatic drain();
        node_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (WET_CYCLES + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(32'h0001_0000, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sweep_len;
        int k;
        node_ch.valid      = 0;
        node_ch.depth      = 0;
        node_ch.discharge  = 0;
        node_ch.cell_width = 0;
        node_ch.dry_cell   = 0;
        node_ch.last_node  = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_THRESH;
        cfg_ch.data  = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part, at reset settings and then at others: extremes, dry nodes, empty sweep,
        // a skipped last node, and zero speed once gravity is zero.
        send_node(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 1);
        send_node(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_node(32'd66, 32'h8000_0000, 32'd1, 0, 1);
        send_node(32'd65, 32'h0000_1000, 32'd5, 0, 1);
        send_node(32'h0002_0000, 32'hFFFF_FFFF, 32'h0100_0000, 1, 0);
        send_node(32'h0002_0000, 32'd0, 32'h0100_0000, 1, 1);
        send_node(32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 0);
        send_node(32'h0000_0100, 32'd0, 32'hFFFF_FFFF, 0, 0);
        send_node(32'h0005_0000, 32'h0002_0000, 32'h0001_0000, 1, 1);
        drain();
        write_reg(CFG_THRESH, 32'd0);
        write_reg(CFG_GRAV, 32'd0);
        write_reg(CFG_ORDER, 4'd15);
        write_reg(2'd3, 32'd7);
        send_node(32'd0, 32'h1234_5678, 32'h0001_0000, 0, 0);
        send_node(32'h0004_0000, 32'd0, 32'h0001_0000, 0, 1);
        send_node(32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_node(32'd1, 32'h0000_0001, 32'd0, 0, 1);
        drain();
        write_reg(CFG_THRESH, 32'hFFFF_FFFF);
        write_reg(CFG_GRAV, 32'hFFFF_FFFF);
        write_reg(CFG_ORDER, 4'd0);
        send_node(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);
        send_node(32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF, 0, 1);
        drain();

        // Random phases: short sweeps with random content, varied settings.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_THRESH, (phase % 3 == 0) ? pick32() : $urandom_range(0, 4096));
            write_reg(CFG_GRAV, (phase == 3) ? 32'd0 : pick32());
            write_reg(CFG_ORDER, $urandom_range(0, 15));
            k = 0;
            while (k < 210) begin
                sweep_len = $urandom_range(1, 8);
                for (int n = 0; n < sweep_len; n++) begin
                    send_node(($urandom_range(0, 3) == 0) ? pick32()
                                  : $urandom_range(32'h0000_1000, 32'h0100_0000),
                              pick32(), pick32(), $urandom_range(0, 9) == 0,
                              n == sweep_len - 1);
                    k++;
                end
                // Now and then the sender waits until the checker holds nothing.
                if ($urandom_range(0, 19) == 0) begin
                    node_ch.valid <= 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
